// ----- rtl/core/olist_pkg.sv -----
// Package for the ordered list engine: sizes, request and status codes, memory write type.
package olist_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;

  typedef logic [2:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_CLEAR  = 3'd0;
  localparam action_t ACT_APPEND = 3'd1;
  localparam action_t ACT_INSERT = 3'd2;
  localparam action_t ACT_DELETE = 3'd3;
  localparam action_t ACT_INSKEY = 3'd4;
  localparam action_t ACT_READ   = 3'd5;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BADPOS = 2'd1;
  localparam status_t ST_NOKEY  = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage

// ----- rtl/core/olist_if.sv -----
// Request and response channel interfaces of the ordered list engine.
interface olist_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [6:0]        position;
  logic signed [31:0] value;
  logic signed [31:0] key;

  modport source (output valid, output action, output position, output value, output key,
                  input ready);
  modport sink   (input valid, input action, input position, input value, input key,
                  output ready);
endinterface

interface olist_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] result_value;
  logic [1:0]        status;
  logic [6:0]        length;

  modport source (output valid, output result_value, output status, output length,
                  input ready);
  modport sink   (input valid, input result_value, input status, input length,
                  output ready);
endinterface

// ----- rtl/core/ordered_list_engine.sv -----
// Ordered list engine top level: request sequencer over a one-read, one-write entry store.
// Clear, unused code, bad position, empty-list key search, full append or insert: straight to done.
// Read, append, insert at the tail or delete of the last entry: one memory state, then done.
// Insert/delete moving n entries: shift pipeline, one move per cycle, then drain. Insert before
// key: key scan first, then as an insert if found, else no-key status. One request in flight; the
// next transfer waits until the result is in the output register. rst_ni (async, low) empties.
module ordered_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  olist_req_if.sink   req_i,
  olist_rsp_if.source rsp_o
);

  localparam int CNT_W  = olist_pkg::CNT_W;
  localparam int IDX_W  = olist_pkg::IDX_W;
  localparam int DATA_W = olist_pkg::DATA_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1; // read data returning
  localparam logic [2:0] S_DELRD  = 3'd2; // removed entry returning
  localparam logic [2:0] S_SRCH   = 3'd3; // key scan, one entry per cycle
  localparam logic [2:0] S_SHIFT  = 3'd4; // read/move pipeline
  localparam logic [2:0] S_DRAIN  = 3'd5; // last move write
  localparam logic [2:0] S_INSWR  = 3'd6; // new value write
  localparam logic [2:0] S_DONE   = 3'd7; // hand result to output register

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovld_q, ovld_d;
  logic             pend_q, pend_d;
  logic             rvld_q, rvld_d;
  logic             dir_up_q, dir_up_d;

  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  end_q, end_d;
  logic [IDX_W-1:0]  wa_q, wa_d;
  logic [IDX_W-1:0]  la_q, la_d;
  logic [IDX_W-1:0]  ins_idx_q, ins_idx_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] res_q, res_d;
  olist_pkg::status_t st_q, st_d;
  logic [DATA_W-1:0] out_res_q, out_res_d;
  olist_pkg::status_t out_st_q, out_st_d;
  logic [CNT_W-1:0]  out_len_q, out_len_d;

  olist_pkg::mem_wr_t wr;
  logic [IDX_W-1:0]   raddr;
  logic [DATA_W-1:0]  rdata;

  logic             req_xfer;
  logic             place_go;
  logic [CNT_W-1:0] place_idx;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] la_next;
  logic [CNT_W-1:0] cnt_m1;

  olist_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;

  assign pos_m1  = req_i.position - CNT_W'(1);
  assign la_next = CNT_W'(la_q) + CNT_W'(1);
  assign cnt_m1  = count_q - CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovld_d    = ovld_q;
    pend_d    = pend_q;
    rvld_d    = rvld_q;
    dir_up_d  = dir_up_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    end_d     = end_q;
    wa_d      = wa_q;
    la_d      = la_q;
    ins_idx_d = ins_idx_q;
    val_d     = val_q;
    key_d     = key_q;
    res_d     = res_q;
    st_d      = st_q;
    out_res_d = out_res_q;
    out_st_d  = out_st_q;
    out_len_d = out_len_q;
    wr        = '0;
    raddr     = ptr_q[IDX_W-1:0];
    place_go  = 1'b0;
    place_idx = count_q;

    if (ovld_q && rsp_o.ready) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        raddr = pos_m1[IDX_W-1:0];
        res_d = '0;
        st_d  = olist_pkg::ST_OK;
        if (req_xfer) begin
          pos_d = req_i.position;
          val_d = req_i.value;
          key_d = req_i.key;
          case (req_i.action)
            olist_pkg::ACT_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            olist_pkg::ACT_APPEND: begin
              place_go  = 1'b1;
              place_idx = count_q;
            end
            olist_pkg::ACT_INSERT: begin
              if (req_i.position > count_q) begin
                st_d    = olist_pkg::ST_BADPOS;
                state_d = S_DONE;
              end else begin
                place_go  = 1'b1;
                place_idx = req_i.position;
              end
            end
            olist_pkg::ACT_DELETE: begin
              if (req_i.position == '0 || req_i.position > count_q) begin
                st_d    = olist_pkg::ST_BADPOS;
                state_d = S_DONE;
              end else begin
                state_d = S_DELRD;
              end
            end
            olist_pkg::ACT_INSKEY: begin
              if (count_q == '0) begin
                st_d    = olist_pkg::ST_NOKEY;
                state_d = S_DONE;
              end else begin
                ptr_d   = '0;
                rvld_d  = 1'b0;
                state_d = S_SRCH;
              end
            end
            olist_pkg::ACT_READ: begin
              if (req_i.position == '0 || req_i.position > count_q) begin
                st_d    = olist_pkg::ST_BADPOS;
                state_d = S_DONE;
              end else begin
                state_d = S_RDWAIT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        res_d   = rdata;
        state_d = S_DONE;
      end

      S_DELRD: begin
        res_d = rdata;
        if (pos_q == count_q) begin
          count_d = cnt_m1;
          state_d = S_DONE;
        end else begin
          // close the gap: move entries pos..count-1 down by one
          ptr_d    = pos_q;
          end_d    = cnt_m1[IDX_W-1:0];
          dir_up_d = 1'b0;
          pend_d   = 1'b0;
          state_d  = S_SHIFT;
        end
      end

      S_SRCH: begin
        raddr = ptr_q[IDX_W-1:0];
        if (rvld_q && rdata == key_q) begin
          place_go  = 1'b1;
          place_idx = CNT_W'(la_q);
        end else if (rvld_q && la_next == count_q) begin
          st_d    = olist_pkg::ST_NOKEY;
          state_d = S_DONE;
        end else if (ptr_q < count_q) begin
          rvld_d = 1'b1;
          la_d   = ptr_q[IDX_W-1:0];
          ptr_d  = ptr_q + CNT_W'(1);
        end else begin
          rvld_d = 1'b0;
        end
      end

      S_SHIFT: begin
        // read at ptr, write the word read last cycle one place along
        raddr = ptr_q[IDX_W-1:0];
        if (pend_q) begin
          wr.en   = 1'b1;
          wr.addr = wa_q;
          wr.data = rdata;
        end
        wa_d   = dir_up_q ? ptr_q[IDX_W-1:0] + IDX_W'(1) : ptr_q[IDX_W-1:0] - IDX_W'(1);
        pend_d = 1'b1;
        if (ptr_q[IDX_W-1:0] == end_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = dir_up_q ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
        end
      end

      S_DRAIN: begin
        wr.en   = 1'b1;
        wr.addr = wa_q;
        wr.data = rdata;
        if (dir_up_q) begin
          state_d = S_INSWR;
        end else begin
          count_d = cnt_m1;
          state_d = S_DONE;
        end
      end

      S_INSWR: begin
        wr.en   = 1'b1;
        wr.addr = ins_idx_q;
        wr.data = val_q;
        count_d = count_q + CNT_W'(1);
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!ovld_q || rsp_o.ready) begin
          ovld_d    = 1'b1;
          out_res_d = res_q;
          out_st_d  = st_q;
          out_len_d = count_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Start of an insert: full check, then open a gap at place_idx unless it is the tail
    if (place_go) begin
      if (count_q == CNT_W'(olist_pkg::CAPACITY)) begin
        st_d    = olist_pkg::ST_FULL;
        state_d = S_DONE;
      end else begin
        ins_idx_d = place_idx[IDX_W-1:0];
        if (place_idx == count_q) begin
          state_d = S_INSWR;
        end else begin
          ptr_d    = cnt_m1;
          end_d    = place_idx[IDX_W-1:0];
          dir_up_d = 1'b1;
          pend_d   = 1'b0;
          state_d  = S_SHIFT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovld_q   <= 1'b0;
      pend_q   <= 1'b0;
      rvld_q   <= 1'b0;
      dir_up_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovld_q   <= ovld_d;
      pend_q   <= pend_d;
      rvld_q   <= rvld_d;
      dir_up_q <= dir_up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    pos_q     <= pos_d;
    end_q     <= end_d;
    wa_q      <= wa_d;
    la_q      <= la_d;
    ins_idx_q <= ins_idx_d;
    val_q     <= val_d;
    key_q     <= key_d;
    res_q     <= res_d;
    st_q      <= st_d;
    out_res_q <= out_res_d;
    out_st_q  <= out_st_d;
    out_len_q <= out_len_d;
  end

  assign rsp_o.valid        = ovld_q;
  assign rsp_o.result_value = out_res_q;
  assign rsp_o.status       = out_st_q;
  assign rsp_o.length       = out_len_q;

endmodule

// ----- rtl/core/olist_mem.sv -----
// Entry store: one write port, one read port with registered read data.
module olist_mem (
  input  logic                                clk_i,
  input  olist_pkg::mem_wr_t                  wr_i,
  input  logic [olist_pkg::IDX_W-1:0]         raddr_i,
  output logic [olist_pkg::DATA_W-1:0]        rdata_o
);

  logic [olist_pkg::DATA_W-1:0] mem [olist_pkg::CAPACITY];
  logic [olist_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- dv/ordered_list_engine_tb.sv -----
// Testbench for the ordered list engine: shadow list, scoreboard, random traffic with stalls.
typedef logic [olist_pkg::DATA_W-1:0] word_t;
typedef logic [olist_pkg::CNT_W-1:0]  len_t;

typedef struct {
  word_t              value;
  olist_pkg::status_t status;
  len_t               length;
} olist_result_t;

// Shadow copy of the list; works out each response as its request is transferred.
class olist_tracker;
  word_t         entries [olist_pkg::CAPACITY];
  int unsigned   count;
  olist_result_t pending_results [$];
  int unsigned   errors;

  function new();
    count  = 0;
    errors = 0;
    foreach (entries[i]) entries[i] = '0;
  endfunction

  // Open a slot at idx by shifting the tail up one place.
  function olist_pkg::status_t place(int unsigned idx, word_t v);
    int unsigned i;
    if (idx > count) return olist_pkg::ST_BADPOS;
    if (count >= olist_pkg::CAPACITY) return olist_pkg::ST_FULL;
    for (i = count; i > idx; i--) entries[i] = entries[i-1];
    entries[idx] = v;
    count++;
    return olist_pkg::ST_OK;
  endfunction

  function void note_request(olist_pkg::action_t act, len_t pos, word_t val, word_t key);
    olist_result_t want;
    int unsigned   i;
    want.value  = '0;
    want.status = olist_pkg::ST_OK;
    case (act)
      olist_pkg::ACT_CLEAR:  count = 0;
      olist_pkg::ACT_APPEND: want.status = place(count, val);
      olist_pkg::ACT_INSERT: want.status = place(pos, val);
      olist_pkg::ACT_DELETE: begin
        if (pos == 0 || pos > count) begin
          want.status = olist_pkg::ST_BADPOS;
        end else begin
          want.value = entries[pos-1];
          for (i = pos - 1; i + 1 < count; i++) entries[i] = entries[i+1];
          count--;
        end
      end
      olist_pkg::ACT_INSKEY: begin
        i = 0;
        while (i < count && entries[i] != key) i++;
        if (i >= count) want.status = olist_pkg::ST_NOKEY;
        else want.status = place(i, val);
      end
      olist_pkg::ACT_READ: begin
        if (pos == 0 || pos > count) want.status = olist_pkg::ST_BADPOS;
        else want.value = entries[pos-1];
      end
      default: ;  // unused codes leave the list alone
    endcase
    want.length = len_t'(count);
    pending_results.push_back(want);
  endfunction

  function void report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  function void check_response(word_t rv, logic [1:0] st, len_t len);
    olist_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("response with nothing outstanding: value %0h status %0d len %0d",
                                rv, st, len));
      return;
    end
    want = pending_results.pop_front();
    if (rv !== want.value)
      report_mismatch($sformatf("result_value %0h, wanted %0h", rv, want.value));
    if (st !== want.status)
      report_mismatch($sformatf("status %0d, wanted %0d", st, want.status));
    if (len !== want.length)
      report_mismatch($sformatf("length %0d, wanted %0d", len, want.length));
  endfunction
endclass

module ordered_list_engine_tb;

  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned SEGMENT      = 110;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 2 * olist_pkg::CAPACITY + 16;

  typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_t;

  logic clk_i;
  logic rst_ni;
  bit   no_idle;
  int unsigned cycle_count = 0;

  olist_tracker tracker;

  olist_req_if req_bus ();
  olist_rsp_if rsp_bus ();

  ordered_list_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ordered_list_engine_tb failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none during a no-idle stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Small values give duplicates for key search; extremes hit the sign bit edges.
  function automatic word_t pick_value();
    int unsigned r;
    int          s;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      s = int'($urandom_range(0, 8)) - 4;
      return word_t'(s);
    end
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_request(olist_pkg::action_t act, len_t pos, word_t val, word_t key);
    int unsigned gap;
    req_bus.valid    <= 1'b1;
    req_bus.action   <= act;
    req_bus.position <= pos;
    req_bus.value    <= val;
    req_bus.key      <= key;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    tracker.note_request(act, pos, val, key);
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly well-formed requests against the current shadow list, plus some noise.
  task automatic pick_request(input mix_t mix, output olist_pkg::action_t act, output len_t pos,
                              output word_t val, output word_t key);
    int unsigned r;
    int unsigned cnt;
    int unsigned t_app, t_ins, t_key, t_read;
    cnt = tracker.count;
    val = pick_value();
    key = pick_value();
    pos = '0;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      act = olist_pkg::action_t'($urandom_range(0, 7));
      pos = len_t'($urandom_range(0, 127));
      key = $urandom();
      return;
    end
    if (r < 8 && mix != MIX_GROW) begin
      act = olist_pkg::ACT_CLEAR;
      return;
    end
    case (mix)
      MIX_GROW:     begin t_app = 25; t_ins = 55; t_key = 80; t_read = 90; end
      MIX_BALANCED: begin t_app = 15; t_ins = 35; t_key = 50; t_read = 70; end
      default:      begin t_app = 5;  t_ins = 15; t_key = 25; t_read = 45; end
    endcase
    r = $urandom_range(0, 99);
    if (r < t_app) begin
      act = olist_pkg::ACT_APPEND;
    end else if (r < t_ins) begin
      act = olist_pkg::ACT_INSERT;
      if ($urandom_range(0, 19) == 0) pos = len_t'(cnt + 1);
      else pos = len_t'($urandom_range(0, cnt));
    end else if (r < t_key) begin
      act = olist_pkg::ACT_INSKEY;
      if (cnt > 0 && $urandom_range(0, 9) < 8)
        key = tracker.entries[$urandom_range(0, cnt - 1)];
    end else begin
      act = (r < t_read) ? olist_pkg::ACT_READ : olist_pkg::ACT_DELETE;
      if (cnt == 0 || $urandom_range(0, 19) == 0)
        pos = $urandom_range(0, 1) ? len_t'(cnt + 1) : '0;
      else
        pos = len_t'($urandom_range(1, cnt));
    end
  endtask

  // Response side: ready held for a while, then, outside no-idle stretches, dropped for a random stall.
  initial begin
    rsp_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      rsp_bus.ready <= 1'b1;
      repeat (no_idle ? 50 : $urandom_range(1, 12)) @(posedge clk_i);
      if (!no_idle) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 4) == 1 ? pick_gap() + 1 : 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
      tracker.check_response(rsp_bus.result_value, rsp_bus.status, rsp_bus.length);
  end

  initial begin
    olist_pkg::action_t act;
    len_t               pos;
    word_t              val;
    word_t              key;
    mix_t               mix;
    int unsigned        n;

    tracker          = new();
    no_idle          = 1'b0;
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.action   = olist_pkg::ACT_CLEAR;
    req_bus.position = '0;
    req_bus.value    = '0;
    req_bus.key      = '0;
    mix              = MIX_GROW;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: errors on the empty list, front and tail edits, key search, odd codes.
    send_request(olist_pkg::ACT_READ,   7'd1, '0, '0);
    send_request(olist_pkg::ACT_DELETE, 7'd0, '0, '0);
    send_request(olist_pkg::ACT_INSKEY, 7'd0, 32'd7, 32'd7);
    send_request(olist_pkg::ACT_INSERT, 7'd1, 32'd5, '0);
    send_request(olist_pkg::ACT_DELETE, 7'd1, '0, '0);
    send_request(olist_pkg::ACT_APPEND, 7'd0, 32'h7FFF_FFFF, '0);
    send_request(olist_pkg::ACT_APPEND, 7'd0, 32'h8000_0000, '0);
    send_request(olist_pkg::ACT_INSERT, 7'd0, 32'hFFFF_FFFF, '0);
    send_request(olist_pkg::ACT_INSERT, 7'd3, 32'h0000_0000, '0);
    send_request(olist_pkg::ACT_INSERT, 7'd5, 32'd1, '0);
    send_request(olist_pkg::ACT_INSKEY, 7'd0, 32'd5, 32'h8000_0000);
    send_request(olist_pkg::ACT_INSKEY, 7'd0, 32'd6, 32'd12345);
    send_request(olist_pkg::ACT_INSKEY, 7'd0, 32'd9, 32'hFFFF_FFFF);
    send_request(olist_pkg::ACT_READ,   7'd0, '0, '0);
    send_request(olist_pkg::ACT_READ,   7'd127, '0, '0);
    send_request(olist_pkg::ACT_READ,   7'd64, '0, '0);
    send_request(olist_pkg::ACT_READ,   7'd1, '0, '0);
    send_request(olist_pkg::ACT_READ,   len_t'(tracker.count), '0, '0);
    send_request(olist_pkg::ACT_DELETE, len_t'(tracker.count), '0, '0);
    send_request(olist_pkg::ACT_DELETE, 7'd1, '0, '0);
    send_request(olist_pkg::ACT_DELETE, 7'd3, '0, '0);
    send_request(olist_pkg::action_t'(3'd6), 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(olist_pkg::action_t'(3'd7), 7'd64, 32'h1234_5678, 32'h8765_4321);
    send_request(olist_pkg::ACT_CLEAR,  7'd0, '0, '0);
    send_request(olist_pkg::ACT_READ,   7'd1, '0, '0);

    // Random: segments cycle grow, balanced, shrink so the list fills and drains repeatedly.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT == 0) begin
        mix     = mix_t'((n / SEGMENT) % 3);
        no_idle = ($urandom_range(0, 4) == 0);
      end
      pick_request(mix, act, pos, val, key);
      send_request(act, pos, val, key);
    end
    req_bus.valid <= 1'b0;
    no_idle = 1'b1;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("ordered_list_engine_tb passed");
    end else begin
      $display("ordered_list_engine_tb failed");
    end
    $finish;
  end

endmodule
